// ----- rtl/cift_pkg.sv -----
// Package for the CAN identifier frequency table.
// Holds the table sizing constants, the controller/datapath command and status
// structs, and the slot index helper. No dependencies.
package cift_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 29;
    localparam int CNT_W       = 32;
    localparam int SLOT_W      = 7;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [FILL_W-1:0] t_fill;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [SLOT_W-1:0] t_slot;

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch key, restart scan
        logic scan;    // issue next id read / compare previous one
        logic cnt_rd;  // read count of the hit slot
        logic upd;     // write incremented count, load result
        logic ins;     // insert new id or drop, load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;      // registered id read matched the key
        logic miss;     // all filled slots scanned, no match
        logic out_free; // result register can take a new item
    } t_status;

    // slot index as seen on the result port (truncated or zero-extended)
    function automatic t_slot slot_of(input t_idx idx);
        logic [IDX_W+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, idx};
        return w[SLOT_W-1:0];
    endfunction

endpackage

// ----- rtl/cift_ctrl.sv -----
// Controller for the CAN identifier frequency table.
// Sequences accept, scan, count update / insert and result load.
// Depends on cift_pkg.
module cift_ctrl
    import cift_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CNT_RD,
        S_UPD,
        S_INS
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit) begin
                    n_state = S_CNT_RD;
                end else if (i_status.miss) begin
                    n_state = S_INS;
                end
            end
            S_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                if (i_status.out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_INS: begin
                if (i_status.out_free) begin
                    o_cmd.ins = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/cift_datapath.sv -----
// Datapath for the CAN identifier frequency table.
// Holds the id and count memories, fill level, scan pointer and result register.
// Depends on cift_pkg.
module cift_datapath
    import cift_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_status o_status,
    input  t_id     i_can_id,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_slot   o_slot_index,
    output t_cnt    o_hit_count,
    output logic    o_is_new,
    output logic    o_dropped
);

    t_id   id_mem  [TABLE_DEPTH];
    t_cnt  cnt_mem [TABLE_DEPTH];

    t_id   r_key;
    t_fill r_fill;
    t_fill r_rd_idx;
    logic  r_cmp_vld;
    t_idx  r_cmp_slot;
    t_id   r_id_q;
    t_cnt  r_cnt_q;

    logic  r_o_valid;
    t_slot r_o_slot;
    t_cnt  r_o_cnt;
    logic  r_o_new;
    logic  r_o_drop;

    logic  hit;
    logic  more;
    logic  issue;
    logic  room;
    logic  out_free;
    t_cnt  cnt_inc;

    assign hit      = r_cmp_vld && (r_id_q == r_key);
    assign more     = (r_rd_idx < r_fill);
    assign issue    = i_cmd.scan && !hit && more;
    assign room     = (r_fill < FILL_W'(TABLE_DEPTH));
    assign out_free = !r_o_valid || !i_out_stall;
    assign cnt_inc  = (r_cnt_q == '1) ? r_cnt_q : r_cnt_q + 1'b1;

    assign o_status.hit      = hit;
    assign o_status.miss     = !hit && !r_cmp_vld && !more;
    assign o_status.out_free = out_free;

    // id memory: one read port for the scan, one write port for inserts
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && room) begin
            id_mem[r_fill[IDX_W-1:0]] <= r_key;
        end
        if (issue) begin
            r_id_q <= id_mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    // count memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            cnt_mem[r_cmp_slot] <= cnt_inc;
        end else if (i_cmd.ins && room) begin
            cnt_mem[r_fill[IDX_W-1:0]] <= CNT_W'(1);
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_q <= cnt_mem[r_cmp_slot];
        end
    end

    // key and scan slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= i_can_id;
        end
        if (issue) begin
            r_cmp_slot <= r_rd_idx[IDX_W-1:0];
        end
    end

    // scan control and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan && !hit) begin
                r_cmp_vld <= more;
                if (more) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (i_cmd.ins && room) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.upd || i_cmd.ins) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_o_slot <= slot_of(r_cmp_slot);
            r_o_cnt  <= cnt_inc;
            r_o_new  <= 1'b0;
            r_o_drop <= 1'b0;
        end else if (i_cmd.ins) begin
            if (room) begin
                r_o_slot <= slot_of(r_fill[IDX_W-1:0]);
                r_o_cnt  <= CNT_W'(1);
                r_o_new  <= 1'b1;
                r_o_drop <= 1'b0;
            end else begin
                r_o_slot <= '0;
                r_o_cnt  <= '0;
                r_o_new  <= 1'b0;
                r_o_drop <= 1'b1;
            end
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_slot_index = r_o_slot;
    assign o_hit_count  = r_o_cnt;
    assign o_is_new     = r_o_new;
    assign o_dropped    = r_o_drop;

endmodule

// ----- rtl/can_id_frequency_table_top.sv -----
// Top level of the CAN identifier frequency table.
// Joins the controller (cift_ctrl) and the datapath (cift_datapath).
// Depends on cift_pkg.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one item, the 29-bit
//   identifier i_can_id. An item is taken at a clock edge with valid high
//   and stall low. Output channel: o_out_valid / i_out_stall carry one
//   result item per input item (slot, count, new flag, drop flag).
//   Sequence: the identifier memory is read one slot per cycle with a
//   registered read, and each read is compared with the key. A hit then
//   reads the count, then writes it back and loads the result; a miss
//   inserts (or drops) the item and loads the result. The controller
//   returns to idle before the next item is taken. One item is worked
//   on at a time.
//   Stall: the result register holds its item while i_out_stall is high;
//   the next item may be accepted and scanned meanwhile, and waits at the
//   load step until the register is free.
//   Reset: synchronous, active low; clears the fill level (table empty),
//   the controller state and the output valid. Table memories are not
//   cleared: only slots below the fill level are ever read.
module can_id_frequency_table_top
    import cift_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [28:0] i_can_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_slot_index,
    output logic [31:0] o_hit_count,
    output logic        o_is_new,
    output logic        o_dropped
);

    t_cmd    cmd;
    t_status status;

    cift_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cift_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_can_id     (i_can_id),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_slot_index (o_slot_index),
        .o_hit_count  (o_hit_count),
        .o_is_new     (o_is_new),
        .o_dropped    (o_dropped)
    );

    // a result is never both new and dropped
    a_new_xor_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_new && o_dropped))
        else $error("result flagged both new and dropped");

    // dropped items report slot 0 and count 0
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dropped) |-> (o_slot_index == '0 && o_hit_count == '0))
        else $error("dropped item carries nonzero slot or count");

    // a recorded identifier always has a nonzero count
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_dropped) |-> (o_hit_count != '0))
        else $error("recorded item with zero count");

    // one item at a time: accepting an item closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again right after an accept");

endmodule
